// File: hw/rtl/fqsa_pkg.sv
package fqsa_pkg;

   // Default queue depth
   localparam int DEPTH_DEF = 16;

   // Request codes
   typedef enum logic [1:0] {
      MODE_ENQ = 2'd0,
      MODE_DEQ = 2'd1,
      MODE_SRCH = 2'd2,
      MODE_AVG = 2'd3
   } mode_type;

   // Result status codes
   typedef enum logic [1:0] {
      STAT_OK = 2'd0,
      STAT_FULL = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   // Request beat
   typedef struct packed {
      mode_type mode;
      logic signed [31:0] value;
   } req_type;

   // Response beat
   typedef struct packed {
      status_type status;
      logic signed [31:0] data_out;
      logic found;
      logic signed [35:0] total;
      logic signed [39:0] mean;
      logic [4:0] occupancy;
   } rsp_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WALK,
      ST_DRAIN,
      ST_DIVINIT,
      ST_DIV,
      ST_FINISH
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;
      logic push;
      logic pop;
      logic rd_issue;
      logic div_start;
      logic div_step;
      logic rsp_load;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      mode_type mode;
      logic skip;
      logic empty;
      logic walk_last;
      logic div_last;
      logic rsp_free;
   } stat_type;

endpackage

// File: hw/rtl/fqsa_ctrl.sv
module fqsa_ctrl
   import fqsa_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input stat_type st,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (st.skip) begin
               state_in = ST_FINISH;
            end else begin
               unique case (st.mode)
                  MODE_ENQ: begin
                     cmd.push = 1'b1;
                     state_in = ST_FINISH;
                  end
                  MODE_DEQ: begin
                     cmd.rd_issue = 1'b1;
                     cmd.pop = 1'b1;
                     state_in = ST_DRAIN;
                  end
                  MODE_SRCH, MODE_AVG: begin
                     state_in = st.empty ? ST_FINISH : ST_WALK;
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_WALK: begin
            cmd.rd_issue = 1'b1;
            if (st.walk_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = (st.mode == MODE_AVG) ? ST_DIVINIT : ST_FINISH;
         end
         ST_DIVINIT: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (st.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (st.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: hw/rtl/fqsa_dp.sv
module fqsa_dp
   import fqsa_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
)
(
   input logic clock,
   input logic reset,
   input req_type req_data,
   input cmd_type cmd,
   output stat_type st,
   output logic rsp_valid,
   input logic rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW = $clog2(DEPTH + 1);
   localparam int SW = 33 + $clog2(DEPTH);
   localparam int DW = SW + 8;
   localparam int CW = $clog2(DW + 1);

   function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
      return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
   endfunction

   logic [31:0] mem [DEPTH];

   logic [AW-1:0] head_ff;
   logic [AW-1:0] tail_ff;
   logic [FW-1:0] fill_ff;
   logic [AW-1:0] walk_idx_ff;
   logic [FW-1:0] walk_cnt_ff;
   mode_type mode_ff;
   logic signed [31:0] value_ff;
   status_type status_ff;
   logic signed [31:0] rd_data_ff;
   logic rd_vld_ff;
   logic signed [SW-1:0] acc_ff;
   logic found_ff;
   logic [DW-1:0] q_ff;
   logic [FW-1:0] rem_ff;
   logic neg_ff;
   logic [CW-1:0] div_cnt_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   logic full;
   logic empty;
   logic [DW-1:0] dividend;
   logic [DW-1:0] div_mag;
   logic [FW:0] trial;
   logic fits;
   logic [DW-1:0] mean_full;
   rsp_type rsp_in;

   assign full = (fill_ff == FW'(DEPTH));
   assign empty = (fill_ff == '0);

   // Write on push, registered read at the walk pointer
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[tail_ff] <= value_ff;
      end
      rd_data_ff <= mem[walk_idx_ff];
   end

   // Queue pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (cmd.push) begin
            tail_ff <= next_idx(tail_ff);
            fill_ff <= fill_ff + FW'(1);
         end else if (cmd.pop) begin
            head_ff <= next_idx(head_ff);
            fill_ff <= fill_ff - FW'(1);
         end
      end
   end

   // Latch request and decide status up front
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_data.mode;
         value_ff <= req_data.value;
         if (req_data.mode == MODE_ENQ && full) begin
            status_ff <= STAT_FULL;
         end else if ((req_data.mode == MODE_DEQ || req_data.mode == MODE_AVG) && empty) begin
            status_ff <= STAT_EMPTY;
         end else begin
            status_ff <= STAT_OK;
         end
      end
   end

   // Walk entries from head, accumulate sum and match flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.rd_issue;
      end
      if (cmd.load) begin
         walk_idx_ff <= head_ff;
         walk_cnt_ff <= '0;
         acc_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         if (cmd.rd_issue) begin
            walk_idx_ff <= next_idx(walk_idx_ff);
            walk_cnt_ff <= walk_cnt_ff + FW'(1);
         end
         if (rd_vld_ff) begin
            acc_ff <= acc_ff + SW'(rd_data_ff);
            if (rd_data_ff == value_ff) begin
               found_ff <= 1'b1;
            end
         end
      end
   end

   // Restoring divide of |sum * 256| by the count, one bit per cycle
   assign dividend = {acc_ff, 8'b0};
   assign div_mag = acc_ff[SW-1] ? (~dividend + DW'(1)) : dividend;
   assign trial = {rem_ff, q_ff[DW-1]};
   assign fits = (trial >= {1'b0, fill_ff});

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         q_ff <= div_mag;
         rem_ff <= '0;
         neg_ff <= acc_ff[SW-1];
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         q_ff <= {q_ff[DW-2:0], fits};
         rem_ff <= fits ? FW'(trial - {1'b0, fill_ff}) : FW'(trial);
         div_cnt_ff <= div_cnt_ff + CW'(1);
      end
   end

   assign mean_full = neg_ff ? (~q_ff + DW'(1)) : q_ff;

   // Assemble the response beat
   always_comb begin
      rsp_in = '0;
      rsp_in.status = status_ff;
      rsp_in.occupancy = 5'(fill_ff);
      if (status_ff == STAT_OK) begin
         unique case (mode_ff)
            MODE_DEQ: rsp_in.data_out = acc_ff[31:0];
            MODE_SRCH: rsp_in.found = found_ff;
            MODE_AVG: begin
               rsp_in.total = 36'(acc_ff);
               rsp_in.mean = mean_full[39:0];
            end
            default: rsp_in = rsp_in;
         endcase
      end
   end

   // Output register, held until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   assign st.mode = mode_ff;
   assign st.skip = (status_ff != STAT_OK);
   assign st.empty = empty;
   assign st.walk_last = (walk_cnt_ff == fill_ff - FW'(1));
   assign st.div_last = (div_cnt_ff == CW'(DW - 1));
   assign st.rsp_free = !rsp_valid_ff || rsp_ready;

   // Checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(DEPTH))
      else $error("fill count exceeds depth");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !full)
      else $error("push into full queue");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !empty)
      else $error("pop from empty queue");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before taken");

endmodule

// File: hw/rtl/fifo_queue_search_average.sv
// Bounded FIFO of signed 32-bit values serving enqueue, dequeue, search and
// sum/average requests, one request at a time, one response per request.
// Search walks the stored entries through the single memory read port, one
// per cycle. Average walks the same way, then divides sum*256 by the entry
// count in a restoring divider that produces one quotient bit per cycle
// over 41 + clog2(DEPTH) bits. Requests that see a full or empty queue
// skip the queue work and answer directly. A new request is taken while
// the previous response still waits in the output register; the next
// response waits in ST_FINISH until that register is free.
module fifo_queue_search_average
   import fqsa_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
)
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input req_type req_data,
   output logic rsp_valid,
   input logic rsp_ready,
   output rsp_type rsp_data
);

   cmd_type cmd;
   stat_type st;

   // Sequencer
   fqsa_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .st(st),
      .cmd(cmd)
   );

   // Storage, accumulator, divider and output register
   fqsa_dp #(
      .DEPTH(DEPTH)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .req_data(req_data),
      .cmd(cmd),
      .st(st),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

endmodule
